// ----- rtl/core/edt_pkg.sv -----
`default_nettype none

package edt_pkg;

   localparam int RECEIVER_W = 16;
   localparam int SIGNAL_W   = 8;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int PENDING_W  = 4;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 64;

   localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TAKEN     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   localparam logic CMD_POST = 1'b0;
   localparam logic CMD_TAKE = 1'b1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [SIGNAL_W-1:0]       signal;
      logic [RECEIVER_W-1:0]     receiver;
   } event_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      event_type            evt;
      logic [PENDING_W-1:0] pending;
   } result_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/core/edt_slot_ram.sv -----
`default_nettype none

module edt_slot_ram #(
   parameter int DEPTH = 10,
   parameter int AW    = 4
) (
   input  wire logic                 clock,
   input  wire edt_pkg::mem_ctl_type mem_ctl,
   input  wire logic [AW-1:0]        mem_addr,
   input  wire edt_pkg::event_type   mem_wdata,
   output      edt_pkg::event_type   mem_rdata
);

   edt_pkg::event_type mem_ff [DEPTH];
   edt_pkg::event_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         mem_ff[mem_addr] <= mem_wdata;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= mem_ff[mem_addr];
      end
   end

   assign mem_rdata = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/core/edt_engine.sv -----
`default_nettype none

module edt_engine #(
   parameter int SLOT_COUNT = 10,
   parameter int AW         = 4,
   parameter int CW         = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire logic                 req_cmd,
   input  wire edt_pkg::event_type   req_evt,
   input  wire logic                 out_ready,
   output      logic                 out_valid,
   output      edt_pkg::result_type  out_result,
   output      edt_pkg::mem_ctl_type mem_ctl,
   output      logic [AW-1:0]        mem_addr,
   output      edt_pkg::event_type   mem_wdata,
   input  wire edt_pkg::event_type   mem_rdata
);

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_CHECK   = 2'd1;
   localparam logic [1:0] S_COMPARE = 2'd2;
   localparam logic [1:0] S_FINISH  = 2'd3;

   logic [1:0]                     state_ff, state_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  count_ff, count_in;
   logic [SLOT_COUNT-1:0]          occ_ff, occ_in;
   logic                           cmd_ff, cmd_in;
   edt_pkg::event_type             evt_ff, evt_in;
   edt_pkg::event_type             take_evt_ff, take_evt_in;
   logic [edt_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [AW-1:0]                  slot;
   logic                           at_end;

   assign slot   = idx_ff[AW-1:0];
   assign at_end = (idx_ff == CW'(SLOT_COUNT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      cmd_ff      <= cmd_in;
      evt_ff      <= evt_in;
      take_evt_ff <= take_evt_in;
      status_ff   <= status_in;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      cmd_in      = cmd_ff;
      evt_in      = evt_ff;
      take_evt_in = take_evt_ff;
      status_in   = status_ff;
      occ_in      = occ_ff;
      count_in    = count_ff;
      mem_ctl     = '0;
      mem_addr    = slot;
      mem_wdata   = evt_ff;
      out_valid   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               evt_in   = req_evt;
               idx_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (at_end) begin
               status_in   = (cmd_ff == edt_pkg::CMD_TAKE) ? edt_pkg::ST_EMPTY
                                                           : edt_pkg::ST_FULL;
               take_evt_in = '0;
               state_in    = S_FINISH;
            end else if (cmd_ff == edt_pkg::CMD_POST) begin
               if (!occ_ff[slot]) begin
                  status_in   = edt_pkg::ST_STORED;
                  take_evt_in = '0;
                  state_in    = S_FINISH;
               end else begin
                  mem_ctl.rd_en = 1'b1;
                  state_in      = S_COMPARE;
               end
            end else begin
               if (occ_ff[slot]) begin
                  mem_ctl.rd_en = 1'b1;
                  state_in      = S_COMPARE;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end
         end
         S_COMPARE: begin
            if (cmd_ff == edt_pkg::CMD_POST) begin
               if (mem_rdata == evt_ff) begin
                  status_in   = edt_pkg::ST_DUPLICATE;
                  take_evt_in = '0;
                  state_in    = S_FINISH;
               end else begin
                  idx_in   = idx_ff + CW'(1);
                  state_in = S_CHECK;
               end
            end else begin
               status_in   = edt_pkg::ST_TAKEN;
               take_evt_in = mem_rdata;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (status_ff == edt_pkg::ST_STORED) begin
                  mem_ctl.wr_en = 1'b1;
                  occ_in[slot]  = 1'b1;
                  count_in      = count_ff + CW'(1);
               end else if (status_ff == edt_pkg::ST_TAKEN) begin
                  occ_in[slot] = 1'b0;
                  count_in     = count_ff - CW'(1);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign out_result.status  = status_ff;
   assign out_result.evt     = take_evt_ff;
   assign out_result.pending = edt_pkg::PENDING_W'(count_in);

   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      $countones(occ_ff) == int'(count_ff))
      else $error("pending count disagrees with occupancy flags");

   a_write_to_free_slot: assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en |-> (!at_end && !occ_ff[slot]))
      else $error("store into an occupied slot");

   a_take_lowers_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid && out_ready && status_ff == edt_pkg::ST_TAKEN)
      |=> count_ff == $past(count_ff) - CW'(1))
      else $error("take did not lower pending count");

   a_no_change_when_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> $stable(occ_ff))
      else $error("occupancy changed outside commit");

endmodule

`default_nettype wire

// ----- rtl/core/dedup_pending_event_table.sv -----
// post scans from slot 0, reading and comparing each occupied slot, until it finds a free
// slot or a duplicate; take skips free slots up to the lowest occupied one; the longest
// scan is a post into a full table
// one request at a time, bounded by the slot scan over the single-port slot memory
// next request accepted while a finished response waits in the output register
// reset: synchronous, active high; clears occupancy flags and count, no clearing pass
`default_nettype none

module dedup_pending_event_table #(
   parameter int SLOT_COUNT = 10
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [edt_pkg::REQ_DATA_W-1:0]  req_tdata,  // receiver, signal, value
   input  wire logic [0:0]                      req_tuser,  // command
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [edt_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // receiver, signal, value, pending
   output      logic [edt_pkg::STATUS_W-1:0]    rsp_tuser   // status
);

   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CW = $clog2(SLOT_COUNT + 1);

   edt_pkg::event_type   req_evt;
   edt_pkg::mem_ctl_type mem_ctl;
   logic [AW-1:0]        mem_addr;
   edt_pkg::event_type   mem_wdata;
   edt_pkg::event_type   mem_rdata;
   logic                 eng_out_valid;
   logic                 eng_out_ready;
   edt_pkg::result_type  eng_result;
   logic                 rsp_valid_ff;
   edt_pkg::result_type  rsp_result_ff;

   assign req_evt = edt_pkg::event_type'(req_tdata);

   edt_engine #(
      .SLOT_COUNT (SLOT_COUNT),
      .AW         (AW),
      .CW         (CW)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_cmd    (req_tuser[0]),
      .req_evt    (req_evt),
      .out_ready  (eng_out_ready),
      .out_valid  (eng_out_valid),
      .out_result (eng_result),
      .mem_ctl    (mem_ctl),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata)
   );

   edt_slot_ram #(
      .DEPTH (SLOT_COUNT),
      .AW    (AW)
   ) u_slot_ram (
      .clock     (clock),
      .mem_ctl   (mem_ctl),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   assign eng_out_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_out_valid && eng_out_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_out_valid && eng_out_ready) begin
         rsp_result_ff <= eng_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_result_ff.status;
   assign rsp_tdata  = {4'b0000, rsp_result_ff.pending, rsp_result_ff.evt};

endmodule

`default_nettype wire

// ----- dv/tb_dedup_pending_event_table.sv -----
`timescale 1ns / 1ps

module tb_dedup_pending_event_table;

   localparam int SLOT_COUNT  = 10;
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_REQS  = 500;

   typedef struct packed {
      logic               cmd;
      edt_pkg::event_type evt;
   } event_req_type;

   logic                           clock;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [edt_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // receiver, signal, value
   logic [0:0]                     req_tuser  = '0;  // command
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [edt_pkg::RSP_DATA_W-1:0] rsp_tdata;  // receiver, signal, value, pending
   logic [edt_pkg::STATUS_W-1:0]   rsp_tuser;  // status

   event_req_type       pending_reqs[$];
   edt_pkg::result_type expected_rsps[$];
   edt_pkg::event_type  recent_events[$];
   event_req_type       driven_req;

   bit                 slot_busy[SLOT_COUNT];
   edt_pkg::event_type slot_event[SLOT_COUNT];
   int                 busy_count = 0;

   int sender_gap_pct = 0;
   int stall_pct      = 0;
   int errors         = 0;
   int accepted_reqs  = 0;
   int checked_rsps   = 0;
   int quiet_cycles   = 0;
   int status_seen[5] = '{default: 0};

   dedup_pending_event_table #(
      .SLOT_COUNT(SLOT_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic edt_pkg::result_type apply_to_table(event_req_type item);
      edt_pkg::result_type res;
      res = '0;
      if (item.cmd == edt_pkg::CMD_POST) begin
         res.status = edt_pkg::ST_FULL;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (!slot_busy[i]) begin
               slot_busy[i]  = 1'b1;
               slot_event[i] = item.evt;
               busy_count++;
               res.status = edt_pkg::ST_STORED;
               break;
            end
            if (slot_event[i] == item.evt) begin
               res.status = edt_pkg::ST_DUPLICATE;
               break;
            end
         end
      end else begin
         res.status = edt_pkg::ST_EMPTY;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_busy[i]) begin
               slot_busy[i] = 1'b0;
               res.evt      = slot_event[i];
               busy_count--;
               res.status = edt_pkg::ST_TAKEN;
               break;
            end
         end
      end
      res.pending = 4'(busy_count);
      status_seen[res.status]++;
      return res;
   endfunction

   function automatic event_req_type post_of(logic [15:0] rcv, logic [7:0] sig,
                                             logic [31:0] val);
      event_req_type item;
      item.cmd          = edt_pkg::CMD_POST;
      item.evt.receiver = rcv;
      item.evt.signal   = sig;
      item.evt.value    = val;
      return item;
   endfunction

   // small field ranges make duplicates and near misses common
   function automatic event_req_type random_request(int post_pct);
      event_req_type item;
      item.cmd          = edt_pkg::CMD_TAKE;
      item.evt.receiver = $urandom;
      item.evt.signal   = $urandom;
      item.evt.value    = $urandom;
      if ($urandom_range(99) < post_pct) begin
         item.cmd = edt_pkg::CMD_POST;
         if (recent_events.size() > 0 && $urandom_range(99) < 40) begin
            item.evt = recent_events[$urandom_range(recent_events.size() - 1)];
         end else begin
            if ($urandom_range(99) < 60) begin
               item.evt.receiver = $urandom_range(3);
               item.evt.signal   = $urandom_range(3);
               item.evt.value    = $urandom_range(1) ? -1 : $urandom_range(2);
            end
            recent_events.push_back(item.evt);
            if (recent_events.size() > 16) void'(recent_events.pop_front());
         end
      end
      return item;
   endfunction

   task automatic report_mismatch(string msg);
      errors++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s got %h want %h",
                                   checked_rsps, name, got, want));
   endtask

   task automatic check_response();
      edt_pkg::result_type want;
      if (expected_rsps.size() == 0) begin
         report_mismatch($sformatf("response with status %0d and nothing expected",
                                   rsp_tuser));
         return;
      end
      want = expected_rsps.pop_front();
      check_field("status", 32'(rsp_tuser), 32'(want.status));
      check_field("receiver_id", 32'(rsp_tdata[15:0]), 32'(want.evt.receiver));
      check_field("signal_number", 32'(rsp_tdata[23:16]), 32'(want.evt.signal));
      check_field("signal_value", rsp_tdata[55:24], want.evt.value);
      check_field("pending_events", 32'(rsp_tdata[59:56]), 32'(want.pending));
      checked_rsps++;
   endtask

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_tvalid || expected_rsps.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_rsps.push_back(apply_to_table(driven_req));
            accepted_reqs++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
               driven_req = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= driven_req.cmd;
               req_tdata  <= driven_req.evt;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("timeout after %0d quiet cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int gap_by_phase[4];
      int stall_by_phase[4];
      int count;
      int burst_len;
      int post_pct;
      gap_by_phase   = '{0, 71, 0, 10};
      stall_by_phase = '{0, 0, 71, 10};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty take, extremes, duplicate, fill to full, full and duplicate while full,
      // a copy past the first free slot, take with ignored fields
      pending_reqs.push_back(random_request(0));
      pending_reqs.push_back(post_of(16'hffff, 8'hff, 32'h7fffffff));
      pending_reqs.push_back(post_of(16'hffff, 8'hff, 32'h7fffffff));
      pending_reqs.push_back(post_of(16'h0000, 8'h00, 32'h80000000));
      pending_reqs.push_back(post_of(16'h0000, 8'h00, 32'hffffffff));
      for (int i = 0; i < 7; i++)
         pending_reqs.push_back(post_of(16'h1000 + i, 8'(i), 32'(i)));
      pending_reqs.push_back(post_of(16'h2000, 8'h55, 32'h5555aaaa));
      pending_reqs.push_back(post_of(16'h1000, 8'h00, 32'h00000001));
      pending_reqs.push_back(post_of(16'h0000, 8'h00, 32'h80000000));
      pending_reqs.push_back(random_request(0));
      pending_reqs.push_back(post_of(16'h0000, 8'h00, 32'hffffffff));
      pending_reqs.push_back(random_request(0));
      pending_reqs.push_back(random_request(0));
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         sender_gap_pct = gap_by_phase[p];
         stall_pct      = stall_by_phase[p];
         count = 0;
         while (count < PHASE_REQS) begin
            burst_len = $urandom_range(24, 1);
            case ($urandom_range(2))
               0: post_pct = 85;
               1: post_pct = 50;
               default: post_pct = 15;
            endcase
            for (int i = 0; i < burst_len; i++)
               pending_reqs.push_back(random_request(post_pct));
            count += burst_len;
         end
         wait_drained();
      end
      sender_gap_pct = 0;
      stall_pct      = 0;

      repeat (2 * SLOT_COUNT + 13) @(posedge clock);
      if (expected_rsps.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_rsps.size()));

      $display("requests %0d, responses checked %0d, mismatches %0d",
               accepted_reqs, checked_rsps, errors);
      $display("stored %0d, duplicate %0d, full %0d, taken %0d, empty %0d",
               status_seen[edt_pkg::ST_STORED], status_seen[edt_pkg::ST_DUPLICATE],
               status_seen[edt_pkg::ST_FULL], status_seen[edt_pkg::ST_TAKEN],
               status_seen[edt_pkg::ST_EMPTY]);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/edt_pkg.sv
rtl/core/edt_slot_ram.sv
rtl/core/edt_engine.sv
rtl/core/dedup_pending_event_table.sv
dv/tb_dedup_pending_event_table.sv
